// File: hdl/sls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Strided load/store unit package
// Shared widths, codes, transaction and configuration types, helper functions.
// ----------------------------------------------------------------------------
package sls_pkg;

   localparam int ADDR_W     = 16;   // internal address register width
   localparam int COUNT_W    = 32;   // internal transfer counter width
   localparam int LEN_W      = 16;
   localparam int WORD_W     = 64;
   localparam int MASK_W     = 8;
   localparam int STRIDE_W   = 16;
   localparam int MODE_W     = 3;
   localparam int MEM_ADDR_W = 16;   // address field of a result
   localparam int CNT_OUT_W  = 32;   // counter fields of a result
   localparam int CSR_DATA_W = 16;   // widest register
   localparam int CSR_IDX_W  = 1;

   // access modes
   localparam logic [MODE_W-1:0] MODE_BCAST_BYTE = 3'd4;
   localparam logic [MODE_W-1:0] MODE_BCAST_HALF = 3'd5;
   localparam logic [MODE_W-1:0] MODE_BCAST_WORD = 3'd6;

   // byte masks per element size
   localparam logic [MASK_W-1:0] MASK_BYTE = 8'h01;
   localparam logic [MASK_W-1:0] MASK_HALF = 8'h03;
   localparam logic [MASK_W-1:0] MASK_WORD = 8'h0F;
   localparam logic [MASK_W-1:0] MASK_DBL  = 8'hFF;

   localparam logic [MODE_W-1:0]   MODE_RESET   = '0;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACCESS_MODE    = 1'b0,
      CSR_ELEMENT_STRIDE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_PREFETCH = 2'd1,
      PH_BUSY     = 2'd2,
      PH_DONE     = 2'd3
   } phase_type;

   typedef struct packed {
      logic              load_address;
      logic              load_length;
      logic [LEN_W-1:0]  address_or_length;
      logic              start_req;
      logic              start_is_store;
      logic              store_valid;
      logic [WORD_W-1:0] store_word;
      logic              next_request;
      logic [WORD_W-1:0] memory_read_word;
      logic              clear_counters;
   } req_type;

   typedef struct packed {
      logic                  done_res;
      logic                  busy_res;
      logic                  mem_enable;
      logic                  mem_write;
      logic [MEM_ADDR_W-1:0] mem_address;
      logic [MASK_W-1:0]     mem_byte_mask;
      logic [WORD_W-1:0]     mem_write_word;
      logic [WORD_W-1:0]     load_word;
      logic                  load_valid;
      logic                  store_ready;
      logic [CNT_OUT_W-1:0]  stores_done_count;
      logic [CNT_OUT_W-1:0]  loads_done_count;
   } rsp_type;

   // decoded configuration handed from the register block to the controller
   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [STRIDE_W-1:0] byte_stride;
      logic [MASK_W-1:0]   byte_mask;
   } cfg_type;

   function automatic logic [MASK_W-1:0] mask_of(input logic [MODE_W-1:0] mode);
      logic [MASK_W-1:0] m;
      case (mode[1:0])
         2'd0:    m = MASK_BYTE;
         2'd1:    m = MASK_HALF;
         2'd2:    m = MASK_WORD;
         default: m = MASK_DBL;
      endcase
      return m;
   endfunction

   // replicate the element across the word in broadcast modes
   function automatic logic [WORD_W-1:0] expand_word(input logic [MODE_W-1:0] mode,
                                                     input logic [WORD_W-1:0] raw);
      logic [WORD_W-1:0] v;
      case (mode)
         MODE_BCAST_BYTE: v = {8{raw[7:0]}};
         MODE_BCAST_HALF: v = {4{raw[15:0]}};
         MODE_BCAST_WORD: v = {2{raw[31:0]}};
         default:         v = raw;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// File: hdl/sls_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Strided load/store unit channels
// Valid/ready channels carrying request and response transactions.
// ----------------------------------------------------------------------------
interface sls_req_if;
   logic            valid;
   logic            ready;
   sls_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface sls_rsp_if;
   logic            valid;
   logic            ready;
   sls_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/sls_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Strided load/store unit registers
// Holds access mode and element stride; derives byte stride and byte mask.
// ----------------------------------------------------------------------------
module sls_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [sls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sls_pkg::CSR_DATA_W-1:0] csr_wdata,
   output sls_pkg::cfg_type                    cfg
);

   logic [sls_pkg::MODE_W-1:0]   mode_ff;
   logic [sls_pkg::STRIDE_W-1:0] stride_ff;
   logic [sls_pkg::STRIDE_W-1:0] stride_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= sls_pkg::MODE_RESET;
         stride_ff <= sls_pkg::STRIDE_RESET;
      end else if (csr_we) begin
         case (sls_pkg::csr_index_type'(csr_index))
            sls_pkg::CSR_ACCESS_MODE:    mode_ff   <= csr_wdata[sls_pkg::MODE_W-1:0];
            sls_pkg::CSR_ELEMENT_STRIDE: stride_ff <= csr_wdata[sls_pkg::STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   // zero stride counts as one element; product wraps to stride width
   assign stride_eff = (stride_ff == '0) ? sls_pkg::STRIDE_W'(1) : stride_ff;

   always_comb begin
      cfg.mode        = mode_ff;
      cfg.byte_stride = stride_eff << mode_ff[1:0];
      cfg.byte_mask   = sls_pkg::mask_of(mode_ff);
   end

endmodule
`default_nettype wire

// File: hdl/sls_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Strided load/store unit controller
// Phase machine, address/length/counter state and per-transaction outputs.
// ----------------------------------------------------------------------------
module sls_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire sls_pkg::req_type req,
   input  wire sls_pkg::cfg_type cfg,
   output sls_pkg::rsp_type     result
);

   sls_pkg::phase_type phase_ff, phase_in;
   logic [sls_pkg::ADDR_W-1:0]  base_ff, base_in, base_ld, base_adv;
   logic [sls_pkg::LEN_W-1:0]   rem_ff, rem_in, rem_ld;
   logic [sls_pkg::MASK_W-1:0]  mask_ff;
   logic                        dir_ff, dir_in;
   logic [sls_pkg::COUNT_W-1:0] sc_ff, sc_in, lc_ff, lc_in;
   logic                        store_fire, load_fire, load_dec, rem_left;
   logic                        en, wr;
   logic [sls_pkg::ADDR_W-1:0]  addr;
   logic [sls_pkg::MASK_W-1:0]  msk;

   // same-transaction loads of base and length are visible immediately
   assign base_ld  = req.load_address ? sls_pkg::ADDR_W'(req.address_or_length) : base_ff;
   assign rem_ld   = req.load_length ? req.address_or_length : rem_ff;
   assign base_adv = base_ld + sls_pkg::ADDR_W'(cfg.byte_stride);

   assign store_fire = (phase_ff == sls_pkg::PH_BUSY) && dir_ff && (rem_ld != '0)
                       && req.store_valid;
   assign load_fire  = (phase_ff == sls_pkg::PH_BUSY) && !dir_ff && req.next_request;
   assign load_dec   = load_fire && (rem_ld != '0);

   assign rem_in   = (store_fire || load_dec) ? rem_ld - sls_pkg::LEN_W'(1) : rem_ld;
   assign rem_left = (rem_in != '0);
   assign base_in  = ((store_fire || load_dec) && rem_left) ? base_adv : base_ld;

   assign sc_in = req.clear_counters ? '0 : sc_ff + sls_pkg::COUNT_W'(store_fire);
   assign lc_in = req.clear_counters ? '0 : lc_ff + sls_pkg::COUNT_W'(load_fire);

   // next phase and direction
   always_comb begin
      phase_in = phase_ff;
      dir_in   = dir_ff;
      case (phase_ff)
         sls_pkg::PH_IDLE: begin
            if (req.start_req) begin
               if (rem_ld == '0) begin
                  phase_in = sls_pkg::PH_DONE;
               end else begin
                  dir_in   = req.start_is_store;
                  phase_in = req.start_is_store ? sls_pkg::PH_BUSY : sls_pkg::PH_PREFETCH;
               end
            end
         end
         sls_pkg::PH_PREFETCH: phase_in = sls_pkg::PH_BUSY;
         sls_pkg::PH_BUSY: begin
            if (!rem_left) phase_in = sls_pkg::PH_DONE;
         end
         default: begin
            phase_in = sls_pkg::PH_IDLE;
            dir_in   = 1'b0;
         end
      endcase
   end

   // memory access for this transaction
   always_comb begin
      en   = 1'b0;
      wr   = 1'b0;
      addr = base_ff;
      msk  = mask_ff;
      case (phase_ff)
         sls_pkg::PH_PREFETCH: en = 1'b1;
         sls_pkg::PH_BUSY: begin
            if (store_fire) begin
               en  = 1'b1;
               wr  = 1'b1;
               msk = cfg.byte_mask;
            end else if (load_dec && rem_left) begin
               en   = 1'b1;
               addr = base_adv;
               msk  = cfg.byte_mask;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      result.done_res          = (phase_ff == sls_pkg::PH_DONE);
      result.busy_res          = (phase_ff == sls_pkg::PH_BUSY) && dir_ff;
      result.mem_enable        = en;
      result.mem_write         = wr;
      result.mem_address       = sls_pkg::MEM_ADDR_W'(addr);
      result.mem_byte_mask     = msk;
      result.mem_write_word    = store_fire ? req.store_word : '0;
      result.load_word         = sls_pkg::expand_word(cfg.mode, req.memory_read_word);
      result.load_valid        = (phase_ff == sls_pkg::PH_BUSY) && !dir_ff;
      result.store_ready       = (phase_ff == sls_pkg::PH_BUSY) && dir_ff && (rem_ld != '0);
      result.stores_done_count = sls_pkg::CNT_OUT_W'(sc_in);
      result.loads_done_count  = sls_pkg::CNT_OUT_W'(lc_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sls_pkg::PH_IDLE;
         base_ff  <= '0;
         rem_ff   <= '0;
         mask_ff  <= '0;
         dir_ff   <= 1'b0;
         sc_ff    <= '0;
         lc_ff    <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         base_ff  <= base_in;
         rem_ff   <= rem_in;
         mask_ff  <= cfg.byte_mask;
         dir_ff   <= dir_in;
         sc_ff    <= sc_in;
         lc_ff    <= lc_in;
      end
   end

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == sls_pkg::PH_DONE |=> phase_ff == sls_pkg::PH_IDLE && !dir_ff)
      else $error("done phase did not return to idle");

   a_prefetch_to_busy: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == sls_pkg::PH_PREFETCH |=> phase_ff == sls_pkg::PH_BUSY && !dir_ff)
      else $error("prefetch did not enter load busy phase");

   a_write_only_store: assert property (@(posedge clock) disable iff (reset)
      result.mem_write |-> result.mem_enable && dir_ff && phase_ff == sls_pkg::PH_BUSY)
      else $error("memory write outside store busy phase");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      accept && load_fire && !req.clear_counters
      |=> lc_ff == $past(lc_ff) + sls_pkg::COUNT_W'(1))
      else $error("load counter did not advance");

endmodule
`default_nettype wire

// File: hdl/sls_rsp_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Strided load/store unit response register
// Holds one result transaction; frees itself as the receiver takes it.
// ----------------------------------------------------------------------------
module sls_rsp_reg (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            load,
   input  wire sls_pkg::rsp_type data,
   output logic                 room,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output sls_pkg::rsp_type     rsp_data
);

   logic             valid_ff, valid_in;
   sls_pkg::rsp_type data_ff;

   assign room     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

// File: hdl/strided_load_store_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Strided load/store unit
// Per-clock controller driving a data memory port with strided accesses.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one transaction of controls per step: base/length load,
//   start, store-side offer, load-side advance, memory read data, counter
//   clear. rsp_chan returns exactly one result transaction per request with
//   the memory command, store/load handshakes, done/busy and both counters.
//   csr_we/csr_index/csr_wdata write access mode (index 0) and element
//   stride (index 1); write them only while no transaction is in flight.
//   An accepted request has its result registered in the response register,
//   valid from the next cycle. Throughput is one transaction per cycle while
//   there is room; the phase machine and counters update in a single pass.
//   A full response register that the receiver is not taking lowers
//   req_chan.ready, and the request side waits; as the receiver takes the
//   result, a new request is accepted in the same cycle.
//   Synchronous reset returns to idle, clears base, length, mask, counters,
//   sets access mode 0 and element stride 1, and empties the response.
// ----------------------------------------------------------------------------
module strided_load_store_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   sls_req_if.sink                             req_chan,
   sls_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [sls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sls_pkg::CSR_DATA_W-1:0] csr_wdata
);

   sls_pkg::cfg_type cfg;
   sls_pkg::rsp_type result;
   logic             room;
   logic             accept;

   assign req_chan.ready = room;
   assign accept         = req_chan.valid && room;

   sls_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sls_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_chan.payload),
      .cfg    (cfg),
      .result (result)
   );

   sls_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .data      (result),
      .room      (room),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_data  (rsp_chan.payload)
   );

endmodule
`default_nettype wire
